[design/assert_macros.svh]
// Assertion macros shared by the JPEG frame header scanner RTL.
// Each macro expects clk and rst_n in scope; rst_n low disables the check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (expr)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, trig, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
    else $error(msg);

`endif

[design/jfhs_pkg.sv]
// Types, marker and status codes, and small decode functions for the
// JPEG frame header scanner. No dependencies.
`default_nettype none

package jfhs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  components;
  } out_item_t;

  // Result status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_TOO_SMALL  = 4'd1;
  localparam logic [3:0] ST_NOT_JPEG   = 4'd2;
  localparam logic [3:0] ST_LEN_TRUNC  = 4'd3;
  localparam logic [3:0] ST_LEN_BAD    = 4'd4;
  localparam logic [3:0] ST_SEG_TRUNC  = 4'd5;
  localparam logic [3:0] ST_FRAME_SHRT = 4'd6;
  localparam logic [3:0] ST_BAD_SIZE   = 4'd7;
  localparam logic [3:0] ST_BAD_COMP   = 4'd8;
  localparam logic [3:0] ST_NOT_FOUND  = 4'd9;

  // Marker bytes
  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_RST0   = 8'hD0;

  // Shortest start-of-frame segment that carries all header fields
  localparam logic [15:0] SOF_MIN_LEN = 16'd8;

  // Markers without a length field
  function automatic logic is_standalone(input logic [7:0] m);
    return (m == MK_TEM) || (m >= MK_RST0 && m <= MK_EOI);
  endfunction

  // Start-of-frame markers: C0-C3, C5-C7, C9-CB, CD-CF
  function automatic logic is_sof(input logic [7:0] m);
    return (m[7:4] == 4'hC) && (m[1:0] != 2'b00 || m[3:2] == 2'b00);
  endfunction

  // Check a captured frame header; size before component count
  function automatic logic [3:0] frame_status(input logic [15:0] flen,
                                              input logic [15:0] w,
                                              input logic [15:0] h,
                                              input logic [7:0]  c);
    logic [3:0] st;
    st = ST_OK;
    if (flen < SOF_MIN_LEN) st = ST_FRAME_SHRT;
    else if (w == 16'd0 || h == 16'd0) st = ST_BAD_SIZE;
    else if (c != 8'd1 && c != 8'd3 && c != 8'd4) st = ST_BAD_COMP;
    return st;
  endfunction

endpackage

`default_nettype wire

[design/jpeg_frame_header_scanner_unit.sv]
// Top level of the JPEG frame header scanner: input register, parser and
// result register. Depends on jfhs_pkg, jfhs_parse and jfhs_out_reg.
// Each byte is held in the input register and its result in the result register.
// Throughput: one byte per cycle unless stalled; the parser handles each byte
// in one pass. The input stage stalls only while a new result waits on a full,
// stalled result register. Synchronous active-low reset empties both registers
// and returns the scanner to the start of a file.
`default_nettype none
`include "assert_macros.svh"

module jpeg_frame_header_scanner_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire jfhs_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output jfhs_pkg::out_item_t       out_item
);
  import jfhs_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      res_valid;
  out_item_t res_item;
  logic      can_take;
  logic      advance;
  logic      accept;

  // Process the held byte unless its result has nowhere to go
  assign advance  = s1_valid_r && (!res_valid || can_take);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

  jfhs_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .item      (s1_item_r),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  jfhs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (advance && res_valid),
    .load_item (res_item),
    .out_stall (out_stall),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `ASSERT_NEXT(a_hold_blocked, s1_valid_r && res_valid && out_valid && out_stall,
    s1_valid_r && $stable(s1_item_r), "blocked byte left the input register")
  `ASSERT_IMPLY(a_stall_needs_item, in_stall, s1_valid_r, "stall with empty input register")

endmodule

`default_nettype wire

[design/jfhs_parse.sv]
// Marker and segment parser: per-file scanner state and the single-pass
// next-state and result logic for one byte. Depends on jfhs_pkg.
`default_nettype none
`include "assert_macros.svh"

module jfhs_parse (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step_en,
  input  wire jfhs_pkg::in_item_t  item,
  output logic                     res_valid,
  output jfhs_pkg::out_item_t      res_item
);
  import jfhs_pkg::*;

  localparam logic [2:0] MODE_SOI0 = 3'd0;
  localparam logic [2:0] MODE_SOI1 = 3'd1;
  localparam logic [2:0] MODE_SCAN = 3'd2;
  localparam logic [2:0] MODE_FILL = 3'd3;
  localparam logic [2:0] MODE_LENH = 3'd4;
  localparam logic [2:0] MODE_LENL = 3'd5;
  localparam logic [2:0] MODE_BODY = 3'd6;

  logic [1:0]  pos_r,    pos_nxt;
  logic [2:0]  mode_r,   mode_nxt;
  logic        mism_r,   mism_nxt;
  logic [15:0] rem_r,    rem_nxt;
  logic [7:0]  lenh_r,   lenh_nxt;
  logic        sof_r,    sof_nxt;
  logic [15:0] flen_r,   flen_nxt;
  logic [15:0] caph_r,   caph_nxt;
  logic [15:0] capw_r,   capw_nxt;
  logic [7:0]  capc_r,   capc_nxt;
  logic        given_r,  given_nxt;

  logic        give;
  logic [3:0]  st;
  logic [7:0]  b;
  logic        last;
  logic [15:0] len_w;
  logic [15:0] len_rem;
  logic [15:0] k_w;
  logic [15:0] rem_dec;

  // Header values as seen by the status check of this byte
  logic [15:0] capw_fin;
  logic [15:0] caph_fin;
  logic [7:0]  capc_fin;

  // Capture values before the end-of-file clear
  logic [15:0] capw_body;
  logic [15:0] caph_body;
  logic [7:0]  capc_body;

  assign b       = item.data_byte;
  assign last    = item.last_byte;
  assign len_w   = {lenh_r, b};
  assign len_rem = len_w - 16'd2;
  assign k_w     = flen_r - rem_r;
  assign rem_dec = (rem_r != 16'd0) ? rem_r - 16'd1 : rem_r;

  // Next state and result for the byte in the input register
  always_comb begin
    pos_nxt  = pos_r;
    mode_nxt = mode_r;
    mism_nxt = mism_r;
    rem_nxt  = rem_r;
    lenh_nxt = lenh_r;
    sof_nxt  = sof_r;
    flen_nxt = flen_r;
    caph_nxt = caph_r;
    capw_nxt = capw_r;
    capc_nxt = capc_r;
    give     = 1'b0;
    st       = ST_OK;

    if (!given_r) begin
      if (pos_r != 2'd3 && last) begin
        give = 1'b1;
        st   = ST_TOO_SMALL;
      end else if (mode_r == MODE_SOI0) begin
        mism_nxt = (b != MK_PREFIX);
        mode_nxt = MODE_SOI1;
      end else if (mode_r == MODE_SOI1) begin
        if (b != MK_SOI) mism_nxt = 1'b1;
        mode_nxt = MODE_SCAN;
      end else if (mism_r) begin
        if (pos_r == 2'd3) begin
          give = 1'b1;
          st   = ST_NOT_JPEG;
        end
      end else begin
        unique case (mode_r)
          MODE_FILL: begin
            if (b == MK_PREFIX) begin
              if (last) begin
                give = 1'b1;
                st   = ST_NOT_FOUND;
              end
            end else if (b == MK_EOI || b == MK_SOS) begin
              give = 1'b1;
              st   = ST_NOT_FOUND;
            end else if (is_standalone(b)) begin
              mode_nxt = MODE_SCAN;
              if (last) begin
                give = 1'b1;
                st   = ST_NOT_FOUND;
              end
            end else if (last) begin
              give = 1'b1;
              st   = ST_LEN_TRUNC;
            end else begin
              sof_nxt  = is_sof(b);
              mode_nxt = MODE_LENH;
            end
          end
          MODE_LENH: begin
            lenh_nxt = b;
            if (last) begin
              give = 1'b1;
              st   = ST_LEN_TRUNC;
            end else begin
              mode_nxt = MODE_LENL;
            end
          end
          MODE_LENL: begin
            if (len_w < 16'd2) begin
              give = 1'b1;
              st   = ST_LEN_BAD;
            end else begin
              flen_nxt = len_w;
              rem_nxt  = len_rem;
              if (len_rem == 16'd0) begin
                if (sof_r) begin
                  give = 1'b1;
                  st   = frame_status(len_w, capw_r, caph_r, capc_r);
                end else begin
                  mode_nxt = MODE_SCAN;
                  if (last) begin
                    give = 1'b1;
                    st   = ST_NOT_FOUND;
                  end
                end
              end else if (last) begin
                give = 1'b1;
                st   = ST_SEG_TRUNC;
              end else begin
                mode_nxt = MODE_BODY;
              end
            end
          end
          MODE_BODY: begin
            // Capture frame header fields by offset within the segment
            if (sof_r) begin
              case (k_w)
                16'd3:   caph_nxt = {b, 8'h00};
                16'd4:   caph_nxt = {caph_r[15:8], b};
                16'd5:   capw_nxt = {b, 8'h00};
                16'd6:   capw_nxt = {capw_r[15:8], b};
                16'd7:   capc_nxt = b;
                default: ;
              endcase
            end
            rem_nxt = rem_dec;
            if (rem_dec == 16'd0) begin
              if (sof_r) begin
                give = 1'b1;
                st   = frame_status(flen_r, capw_nxt, caph_nxt, capc_nxt);
              end else begin
                mode_nxt = MODE_SCAN;
                if (last) begin
                  give = 1'b1;
                  st   = ST_NOT_FOUND;
                end
              end
            end else if (last) begin
              give = 1'b1;
              st   = ST_SEG_TRUNC;
            end
          end
          default: begin
            // Top of scan
            mode_nxt = MODE_SCAN;
            if (last) begin
              give = 1'b1;
              st   = ST_NOT_FOUND;
            end else if (b == MK_PREFIX) begin
              mode_nxt = MODE_FILL;
            end
          end
        endcase
      end
    end

    given_nxt = given_r | give;
    if (pos_r != 2'd3) pos_nxt = pos_r + 2'd1;

    // End of file: return to the reset state for the next file
    if (last) begin
      pos_nxt   = 2'd0;
      mode_nxt  = MODE_SOI0;
      mism_nxt  = 1'b0;
      rem_nxt   = 16'd0;
      lenh_nxt  = 8'd0;
      sof_nxt   = 1'b0;
      flen_nxt  = 16'd0;
      caph_nxt  = 16'd0;
      capw_nxt  = 16'd0;
      capc_nxt  = 8'd0;
      given_nxt = 1'b0;
    end
  end

  // Result item; header fields only on success
  always_comb begin
    res_valid = give;
    res_item.status       = st;
    res_item.image_width  = 16'd0;
    res_item.image_height = 16'd0;
    res_item.components   = 3'd0;
    if (st == ST_OK) begin
      res_item.image_width  = capw_fin;
      res_item.image_height = caph_fin;
      res_item.components   = capc_fin[2:0];
    end
  end

  assign capw_fin = (mode_r == MODE_BODY) ? capw_body : capw_r;
  assign caph_fin = (mode_r == MODE_BODY) ? caph_body : caph_r;
  assign capc_fin = (mode_r == MODE_BODY) ? capc_body : capc_r;

  always_comb begin
    capw_body = capw_r;
    caph_body = caph_r;
    capc_body = capc_r;
    if (sof_r) begin
      case (k_w)
        16'd3:   caph_body = {b, 8'h00};
        16'd4:   caph_body = {caph_r[15:8], b};
        16'd5:   capw_body = {b, 8'h00};
        16'd6:   capw_body = {capw_r[15:8], b};
        16'd7:   capc_body = b;
        default: ;
      endcase
    end
  end

  // Advance scanner state on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 2'd0;
      mode_r  <= MODE_SOI0;
      mism_r  <= 1'b0;
      rem_r   <= 16'd0;
      lenh_r  <= 8'd0;
      sof_r   <= 1'b0;
      flen_r  <= 16'd0;
      caph_r  <= 16'd0;
      capw_r  <= 16'd0;
      capc_r  <= 8'd0;
      given_r <= 1'b0;
    end else if (step_en) begin
      pos_r   <= pos_nxt;
      mode_r  <= mode_nxt;
      mism_r  <= mism_nxt;
      rem_r   <= rem_nxt;
      lenh_r  <= lenh_nxt;
      sof_r   <= sof_nxt;
      flen_r  <= flen_nxt;
      caph_r  <= caph_nxt;
      capw_r  <= capw_nxt;
      capc_r  <= capc_nxt;
      given_r <= given_nxt;
    end
  end

  `ASSERT_NEXT(a_eof_clears, step_en && item.last_byte,
    !given_r && pos_r == 2'd0 && mode_r == MODE_SOI0, "file end did not clear scanner")
  `ASSERT_IMPLY(a_one_result, res_valid, !given_r, "second result for one file")

endmodule

`default_nettype wire

[design/jfhs_out_reg.sv]
// Result register between the parser and the result channel; frees itself
// when its item is taken. Depends on jfhs_pkg.
`default_nettype none
`include "assert_macros.svh"

module jfhs_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load_en,
  input  wire jfhs_pkg::out_item_t  load_item,
  input  wire logic                 out_stall,
  output logic                      can_take,
  output logic                      out_valid,
  output jfhs_pkg::out_item_t       out_item
);
  import jfhs_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  // Room when empty or when the held item leaves this cycle
  assign can_take = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load_en) valid_nxt = 1'b1;
    else if (!out_stall) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load payload; hold while stalled
  always_ff @(posedge clk) begin
    if (load_en) begin
      item_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

  `ASSERT_IMPLY(a_no_overwrite, load_en, can_take, "result loaded over a held item")

endmodule

`default_nettype wire

[sim/tb.sv]
// Testbench for jpeg_frame_header_scanner_unit. It streams whole JPEG files one
// byte per item and checks each file's result against a local predictor.
// Depends on jfhs_pkg and the scanner RTL.
module tb;
  import jfhs_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1600;
  localparam int DRAIN_CYCLES = 8;

  // Marker bytes used by the stimulus beyond those in the package
  localparam logic [7:0] MK_SOF0  = 8'hC0;
  localparam logic [7:0] MK_SOF15 = 8'hCF;
  localparam logic [7:0] MK_DHT   = 8'hC4;
  localparam logic [7:0] MK_DQT   = 8'hDB;
  localparam logic [7:0] MK_APP0  = 8'hE0;
  localparam logic [7:0] MK_COM   = 8'hFE;

  typedef enum logic [3:0] {
    SM_SOI0, SM_SOI1, SM_SCAN, SM_FILL, SM_LENH, SM_LENL, SM_BODY
  } scan_mode_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Result side as settled before the next rising edge
  logic      out_valid_s = 1'b0;
  out_item_t out_item_s = '0;

  // Predicted scanner state for the file in flight
  logic [1:0]  seen_count;
  scan_mode_e  mode;
  logic        soi_bad;
  logic [15:0] seg_left;
  logic [15:0] seg_len;
  logic [7:0]  len_high;
  logic        in_sof;
  logic [15:0] cap_height;
  logic [15:0] cap_width;
  logic [7:0]  cap_comps;
  logic        reported;

  out_item_t   expected_results[$];
  logic [7:0]  file_q[$];
  out_item_t   head;
  int          error_count = 0;
  int          cycle_count = 0;
  int          random_bytes = 0;
  int          out_hold = 0;
  bit          no_idle = 1'b0;

  jpeg_frame_header_scanner_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Return the predictor to the start of a file
  function automatic void restart_file();
    seen_count = '0;
    mode       = SM_SOI0;
    soi_bad    = 1'b0;
    seg_left   = '0;
    seg_len    = '0;
    len_high   = '0;
    in_sof     = 1'b0;
    cap_height = '0;
    cap_width  = '0;
    cap_comps  = '0;
    reported   = 1'b0;
  endfunction

  // Queue the file's one result; frame fields only travel with an ok status
  function automatic void report_status(input logic [3:0] st);
    out_item_t r;
    r = '0;
    r.status = st;
    if (st == ST_OK) begin
      r.image_width  = cap_width;
      r.image_height = cap_height;
      r.components   = cap_comps[2:0];
    end
    expected_results.push_back(r);
    reported = 1'b1;
  endfunction

  // Judge a complete frame header: length, then size, then component count
  function automatic logic [3:0] frame_verdict();
    if (seg_len < 16'd8) return ST_FRAME_SHRT;
    if (cap_width == 16'd0 || cap_height == 16'd0) return ST_BAD_SIZE;
    if (cap_comps != 8'd1 && cap_comps != 8'd3 && cap_comps != 8'd4) return ST_BAD_COMP;
    return ST_OK;
  endfunction

  // Close a segment whose byte count has run out
  function automatic void segment_done(input logic is_last);
    if (in_sof) begin
      report_status(frame_verdict());
    end else begin
      mode = SM_SCAN;
      if (is_last) report_status(ST_NOT_FOUND);
    end
  endfunction

  // Advance the marker scanner by one byte once the start marker is good
  function automatic void scan_step(input logic [7:0] b, input logic is_last);
    logic [15:0] len;
    logic [15:0] pos;
    logic        lone;
    lone = (b == MK_TEM) || (b[7:4] == 4'hD && b[3:0] <= 4'h9);
    case (mode)
      SM_FILL: begin
        if (b == MK_PREFIX) begin
          if (is_last) report_status(ST_NOT_FOUND);
        end else if (b == MK_EOI || b == MK_SOS) begin
          report_status(ST_NOT_FOUND);
        end else if (lone) begin
          mode = SM_SCAN;
          if (is_last) report_status(ST_NOT_FOUND);
        end else if (is_last) begin
          report_status(ST_LEN_TRUNC);
        end else begin
          // Frame markers are C0-CF except C4, C8 and CC
          in_sof = (b[7:4] == 4'hC) && b[3:0] != 4'h4 && b[3:0] != 4'h8 &&
                   b[3:0] != 4'hC;
          mode = SM_LENH;
        end
      end
      SM_LENH: begin
        len_high = b;
        if (is_last) report_status(ST_LEN_TRUNC);
        else mode = SM_LENL;
      end
      SM_LENL: begin
        len = {len_high, b};
        if (len < 16'd2) begin
          report_status(ST_LEN_BAD);
        end else begin
          seg_len  = len;
          seg_left = len - 16'd2;
          if (seg_left == 16'd0) segment_done(is_last);
          else if (is_last) report_status(ST_SEG_TRUNC);
          else mode = SM_BODY;
        end
      end
      SM_BODY: begin
        pos = seg_len - seg_left;
        if (in_sof) begin
          case (pos)
            16'd3: cap_height = {b, 8'h00};
            16'd4: cap_height = cap_height | {8'h00, b};
            16'd5: cap_width  = {b, 8'h00};
            16'd6: cap_width  = cap_width | {8'h00, b};
            16'd7: cap_comps  = b;
            default: ;
          endcase
        end
        if (seg_left != 16'd0) seg_left--;
        if (seg_left == 16'd0) segment_done(is_last);
        else if (is_last) report_status(ST_SEG_TRUNC);
      end
      default: begin
        mode = SM_SCAN;
        if (is_last) report_status(ST_NOT_FOUND);
        else if (b == MK_PREFIX) mode = SM_FILL;
      end
    endcase
  endfunction

  // Predict the effect of one accepted item
  function automatic void predict_byte(input logic [7:0] b, input logic is_last);
    if (!reported) begin
      if (seen_count < 2'd3 && is_last) begin
        report_status(ST_TOO_SMALL);
      end else if (mode == SM_SOI0) begin
        soi_bad = (b != MK_PREFIX);
        mode = SM_SOI1;
      end else if (mode == SM_SOI1) begin
        if (b != MK_SOI) soi_bad = 1'b1;
        mode = SM_SCAN;
      end else if (soi_bad) begin
        if (seen_count == 2'd3) report_status(ST_NOT_JPEG);
      end else begin
        scan_step(b, is_last);
      end
    end
    if (seen_count < 2'd3) seen_count++;
    if (is_last) restart_file();
  endfunction

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic logic [15:0] rand_dim();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3, 4, 5: return 16'($urandom_range(1, 4096));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void start_file();
    file_q = '{MK_PREFIX, MK_SOI};
  endfunction

  // Append a marker segment; the body carries a precision byte of 8, then height,
  // width and component count where a frame header keeps them, and random bytes after
  function automatic void add_segment(input logic [7:0] marker, input logic [15:0] len,
                                      input logic [15:0] h, input logic [15:0] w,
                                      input logic [7:0] comps);
    file_q.push_back(MK_PREFIX);
    file_q.push_back(marker);
    file_q.push_back(len[15:8]);
    file_q.push_back(len[7:0]);
    for (int i = 0; i + 2 < int'(len); i++) begin
      case (i)
        0: file_q.push_back(8'd8);
        1: file_q.push_back(h[15:8]);
        2: file_q.push_back(h[7:0]);
        3: file_q.push_back(w[15:8]);
        4: file_q.push_back(w[7:0]);
        5: file_q.push_back(comps);
        default: file_q.push_back(8'($urandom));
      endcase
    end
  endfunction

  // Send one item after a random gap; hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: b, last_byte: is_last};
    // Judge the stall away from the edge, then take the accepting edge
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    predict_byte(b, is_last);
  endtask

  // Stream the assembled file, flagging its final byte
  task automatic send_file();
    no_idle = ($urandom_range(0, 3) == 0);
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  task automatic test_short_files();
    file_q = '{MK_PREFIX};
    send_file();
    file_q = '{MK_PREFIX, MK_SOI};
    send_file();
    file_q = '{8'h00, 8'h12, MK_PREFIX};
    send_file();
  endtask

  task automatic test_bad_start();
    file_q = '{8'h00, MK_SOI, MK_PREFIX, MK_EOI};
    send_file();
    file_q = '{MK_PREFIX, 8'h00, 8'hAA, 8'h55, MK_PREFIX};
    send_file();
  endtask

  task automatic test_frame_fields();
    start_file();
    add_segment(MK_SOF0, 16'd17, 16'hFFFF, 16'hFFFF, 8'd3);
    send_file();
    start_file();
    add_segment(MK_SOF15, 16'd8, 16'd1, 16'd1, 8'd4);
    send_file();
    start_file();
    add_segment(8'hC1, 16'd8, 16'd1, 16'hFFFF, 8'd1);
    send_file();
    // Zero width, with trailing bytes ignored after the result
    start_file();
    add_segment(8'hC2, 16'd11, 16'd480, 16'd0, 8'd3);
    file_q.push_back(MK_PREFIX);
    file_q.push_back(MK_EOI);
    send_file();
    // Zero height wins over a bad component count
    start_file();
    add_segment(8'hC3, 16'd8, 16'd0, 16'd640, 8'd2);
    send_file();
    start_file();
    add_segment(8'hC5, 16'd8, 16'd10, 16'd10, 8'd0);
    send_file();
    start_file();
    add_segment(8'hCB, 16'd9, 16'd10, 16'd10, 8'hFF);
    send_file();
    // Frame segments too short to hold the header
    start_file();
    add_segment(8'hC6, 16'd7, 16'd10, 16'd10, 8'd3);
    send_file();
    start_file();
    add_segment(8'hC7, 16'd2, 16'd0, 16'd0, 8'd0);
    file_q.push_back(8'h55);
    send_file();
    // Lengths below two
    start_file();
    file_q = {file_q, MK_PREFIX, 8'hC9, 8'h00, 8'h00, 8'h33};
    send_file();
    start_file();
    file_q = {file_q, MK_PREFIX, 8'hCA, 8'h00, 8'h01, 8'h33};
    send_file();
    // Frame behind a table, junk, fill and standalone markers
    start_file();
    add_segment(MK_DHT, 16'd5, 16'hFFFF, 16'hFFFF, 8'hFF);
    file_q = {file_q, 8'h00, MK_PREFIX, MK_PREFIX, MK_PREFIX, 8'hD3, MK_PREFIX, MK_TEM};
    add_segment(MK_SOF0, 16'd8, 16'h1234, 16'h5678, 8'd1);
    send_file();
  endtask

  task automatic test_scan_endings();
    start_file();
    file_q = {file_q, MK_PREFIX, MK_EOI, 8'h00};
    send_file();
    start_file();
    file_q = {file_q, MK_PREFIX, MK_SOS, 8'h00};
    send_file();
    start_file();
    file_q = {file_q, 8'h12, 8'h34};
    send_file();
    start_file();
    file_q = {file_q, MK_PREFIX, MK_PREFIX, MK_PREFIX};
    send_file();
    start_file();
    file_q = {file_q, MK_PREFIX, 8'(MK_RST0 + 8'd7)};
    send_file();
    start_file();
    file_q = {file_q, MK_PREFIX, MK_APP0};
    send_file();
    start_file();
    file_q = {file_q, MK_PREFIX, MK_APP0, 8'h00};
    send_file();
    start_file();
    file_q = {file_q, MK_PREFIX, MK_APP0, 8'h00, 8'h09};
    send_file();
    // Longest length, cut off a few bytes in
    start_file();
    file_q = {file_q, MK_PREFIX, MK_COM, 8'hFF, 8'hFF, 8'h00, 8'h01};
    send_file();
    // Segments that end exactly on the final byte
    start_file();
    add_segment(MK_DQT, 16'd5, 16'd0, 16'd0, 8'd0);
    send_file();
    start_file();
    add_segment(MK_APP0, 16'd2, 16'd0, 16'd0, 8'd0);
    send_file();
  endtask

  task automatic test_random_files();
    int         pick;
    int         v;
    int         cut;
    logic [7:0] m;
    logic [15:0] len;
    while (random_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // Noise, sometimes behind a valid start marker
        if (pick < 5) start_file();
        repeat ($urandom_range(1, 10)) file_q.push_back(8'($urandom));
      end else begin
        start_file();
        if (pick < 15) file_q[$urandom_range(0, 1)] = 8'($urandom);
        // Wander through junk, fill, standalone markers and other segments
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 2))
            0: begin
              repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom_range(0, 8'hFE)));
            end
            1: begin
              repeat ($urandom_range(1, 3)) file_q.push_back(MK_PREFIX);
              v = $urandom_range(0, 9);
              file_q.push_back(v == 9 ? MK_TEM : 8'(MK_RST0 + v));
            end
            default: begin
              case ($urandom_range(0, 2))
                0: m = 8'($urandom_range(2, 8'hBF));
                1: m = 8'($urandom_range(MK_DQT, MK_COM));
                default: m = 8'(MK_DHT + 4 * $urandom_range(0, 2));
              endcase
              add_segment(m, 16'($urandom_range(2, 10)), 16'($urandom), 16'($urandom),
                          8'($urandom));
            end
          endcase
        end
        // Close with a frame header, an end or scan marker, or a long segment
        case ($urandom_range(0, 9))
          7: file_q = {file_q, MK_PREFIX, MK_EOI};
          8: file_q = {file_q, MK_PREFIX, MK_SOS};
          9: begin
            file_q = {file_q, MK_PREFIX, 8'($urandom_range(MK_APP0, MK_COM)),
                      8'($urandom_range(1, 255)), 8'($urandom)};
            repeat ($urandom_range(1, 4)) file_q.push_back(8'($urandom));
          end
          default: begin
            // Pick among C0-C3, C5-C7, C9-CB, CD-CF
            v = $urandom_range(0, 12);
            m = 8'(MK_SOF0 + v + (v >= 4) + (v >= 7) + (v >= 10));
            len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 7))
                                              : 16'(8 + $urandom_range(0, 9));
            v = $urandom_range(0, 2);
            add_segment(m, len, rand_dim(), rand_dim(),
                        ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                    : 8'((v == 0) ? 1 : v + 2));
          end
        endcase
        repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
        // Cut the file short now and then
        if ($urandom_range(0, 3) == 0) begin
          cut = $urandom_range(1, file_q.size());
          file_q = file_q[0:cut-1];
        end
      end
      random_bytes += file_q.size();
      send_file();
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Sample the result side between edges
  always @(negedge clk) begin
    out_valid_s <= out_valid;
    out_item_s  <= out_item;
  end

  // Check each accepted result against the oldest expectation; stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid_s && !out_stall) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual status %0d",
                 $time, out_item_s.status);
      end else begin
        head = expected_results.pop_front();
        check_field("status", head.status, out_item_s.status);
        check_field("image_width", head.image_width, out_item_s.image_width);
        check_field("image_height", head.image_height, out_item_s.image_height);
        check_field("components", head.components, out_item_s.components);
      end
      out_hold = idle_cycles();
    end
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    restart_file();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_files();
    test_bad_start();
    test_frame_fields();
    test_scan_endings();
    test_random_files();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
